// ===== sv/shdlc_rx_pkg.sv =====
package shdlc_rx_pkg;

   localparam logic [7:0] SYM_FLAG = 8'h7E;
   localparam logic [7:0] SYM_ESC = 8'h7D;
   localparam logic [7:0] ESC_FLAG = 8'h5E;
   localparam logic [7:0] ESC_ESC = 8'h5D;
   localparam logic [7:0] ESC_XON = 8'h31;
   localparam logic [7:0] ESC_XOFF = 8'h33;
   localparam logic [7:0] CHR_XON = 8'h11;
   localparam logic [7:0] CHR_XOFF = 8'h13;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam int HEADER_BYTES = 4;
   localparam int LEN_OFFSET = 3;
   localparam int INDEX_W = 6;
   localparam int EMIT_W = 9;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_BAD_ESC = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;
   localparam logic [1:0] KIND_BAD_FRAME = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic bank;
      logic [EMIT_W-1:0] emit_count;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

// ===== sv/shdlc_frame_receiver_core.sv =====
// SHDLC frame receiver. Raw serial bytes enter on the req_ channel, one item per
// accepted byte; deframed results leave on the rsp_ channel.
// The front end hunts for the 0x7E start symbol, undoes 0x7D escapes, stores the
// frame into one of two buffer banks and keeps a running byte sum and the length
// byte, so the closing symbol is checked in the same cycle it is accepted.
// A good frame or an error goes into a two-entry command queue.
// The back end emits a good frame from its bank byte by byte (buffer read, then
// output register), header first and checksum dropped, with rsp_last on the final
// byte; an error is emitted as a single item in the cycle after it is popped. The
// first byte of a frame passes through the queue, buffer read and output register.
// A raw byte is accepted every cycle unless the queue is full or both banks still
// hold frames waiting to be emitted, in which case req_stall is raised.
// When rsp_stall is high the output register holds a valid item and the back end
// waits; the front end carries on until the queue or both banks fill.
// Synchronous reset returns to hunting with an empty queue; buffer contents are
// not cleared and are only read after being written.
module shdlc_frame_receiver_core #(
   parameter int FRAME_BYTES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_frame_byte,
   output logic [5:0] rsp_byte_index,
   output logic rsp_last
);
   import shdlc_rx_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);

   logic q_full;
   logic q_empty;
   logic cmd_push;
   logic cmd_pop;
   cmd_type cmd;
   cmd_type head;
   release_type bank_release;
   logic wr_en;
   logic [AW:0] wr_addr;
   logic [7:0] wr_data;

   shdlc_rx_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .q_full(q_full),
      .cmd_push(cmd_push),
      .cmd(cmd),
      .bank_release(bank_release),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   shdlc_rx_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_cmd(cmd),
      .full(q_full),
      .empty(q_empty),
      .pop(cmd_pop),
      .head(head)
   );

   shdlc_rx_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .head(head),
      .pop(cmd_pop),
      .bank_release(bank_release),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last)
   );

endmodule

// ===== sv/shdlc_rx_front.sv =====
module shdlc_rx_front #(
   parameter int FRAME_BYTES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic q_full,
   output logic cmd_push,
   output shdlc_rx_pkg::cmd_type cmd,
   input  shdlc_rx_pkg::release_type bank_release,
   output logic wr_en,
   output logic [$clog2(FRAME_BYTES):0] wr_addr,
   output logic [7:0] wr_data
);
   import shdlc_rx_pkg::*;

   localparam int CW = $clog2(FRAME_BYTES + 1);
   localparam int AW = $clog2(FRAME_BYTES);
   localparam int LW = (CW > 9) ? CW : 9;

   typedef enum logic [1:0] {M_HUNT, M_COLLECT, M_ESCAPE} mode_type;

   mode_type mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic bank_ff, bank_in;
   logic [1:0] busy_ff, busy_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] lastb_ff, lastb_in;

   logic accept;
   logic store;
   logic [7:0] store_data;
   logic esc_ok;
   logic [7:0] esc_data;
   logic count_full;
   logic frame_good;
   logic [7:0] sum_head;

   assign req_stall = q_full || busy_ff[bank_ff];
   assign accept = req_valid && !req_stall;
   assign count_full = (count_ff == CW'(FRAME_BYTES));
   assign sum_head = sum_ff - lastb_ff;
   assign frame_good = (count_ff >= CW'(HEADER_BYTES + 1))
      && (LW'(count_ff) == LW'(len_ff) + LW'(HEADER_BYTES + 1))
      && (lastb_ff == (~sum_head & BYTE_MASK));

   always_comb begin
      esc_ok = 1'b1;
      case (req_rx_byte)
         ESC_FLAG: esc_data = SYM_FLAG;
         ESC_ESC: esc_data = SYM_ESC;
         ESC_XON: esc_data = CHR_XON;
         ESC_XOFF: esc_data = CHR_XOFF;
         default: begin
            esc_ok = 1'b0;
            esc_data = 8'h00;
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      count_in = count_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      sum_in = sum_ff;
      len_in = len_ff;
      lastb_in = lastb_ff;
      store = 1'b0;
      store_data = req_rx_byte;
      cmd_push = 1'b0;
      cmd.kind = KIND_BYTE;
      cmd.bank = bank_ff;
      cmd.emit_count = EMIT_W'(count_ff - CW'(1));
      wr_en = 1'b0;
      wr_addr = {bank_ff, count_ff[AW-1:0]};
      wr_data = store_data;

      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end

      if (accept) begin
         case (mode_ff)
            M_COLLECT: begin
               if (req_rx_byte == SYM_ESC) begin
                  mode_in = M_ESCAPE;
               end else if (req_rx_byte == SYM_FLAG) begin
                  if (count_ff != '0) begin
                     cmd_push = 1'b1;
                     count_in = '0;
                     if (count_full) begin
                        cmd.kind = KIND_OVERFLOW;
                        mode_in = M_HUNT;
                     end else if (frame_good) begin
                        cmd.kind = KIND_BYTE;
                        mode_in = M_HUNT;
                        busy_in[bank_ff] = 1'b1;
                        bank_in = !bank_ff;
                     end else begin
                        cmd.kind = KIND_BAD_FRAME;
                        mode_in = M_COLLECT;
                     end
                  end
               end else begin
                  store = 1'b1;
               end
            end
            M_ESCAPE: begin
               if (esc_ok) begin
                  mode_in = M_COLLECT;
                  store = 1'b1;
                  store_data = esc_data;
               end else begin
                  cmd_push = 1'b1;
                  cmd.kind = KIND_BAD_ESC;
                  mode_in = M_HUNT;
                  count_in = '0;
               end
            end
            default: begin
               if (req_rx_byte == SYM_FLAG) begin
                  mode_in = M_COLLECT;
                  count_in = '0;
               end
            end
         endcase

         if (store) begin
            if (count_full) begin
               cmd_push = 1'b1;
               cmd.kind = KIND_OVERFLOW;
               mode_in = M_HUNT;
               count_in = '0;
            end else begin
               wr_en = 1'b1;
               wr_data = store_data;
               count_in = count_ff + CW'(1);
               sum_in = (count_ff == '0) ? store_data : sum_ff + store_data;
               lastb_in = store_data;
               if (count_ff == CW'(LEN_OFFSET)) begin
                  len_in = store_data;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_HUNT;
         count_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         count_ff <= count_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
      sum_ff <= sum_in;
      len_ff <= len_in;
      lastb_ff <= lastb_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FRAME_BYTES))
      else $error("Byte count exceeds the frame buffer.");

   a_good_bank_free: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd.kind == KIND_BYTE |-> !busy_ff[bank_ff])
      else $error("Good frame queued on a bank still being emitted.");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !count_full && accept && (mode_ff == M_COLLECT || mode_ff == M_ESCAPE))
      else $error("Buffer write outside a frame or beyond its end.");

endmodule

// ===== sv/shdlc_rx_queue.sv =====
module shdlc_rx_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  shdlc_rx_pkg::cmd_type push_cmd,
   output logic full,
   output logic empty,
   input  logic pop,
   output shdlc_rx_pkg::cmd_type head
);
   import shdlc_rx_pkg::*;

   cmd_type entries_ff [2];
   logic wptr_ff;
   logic rptr_ff;
   logic [1:0] fill_ff;
   logic do_push;
   logic do_pop;

   assign full = (fill_ff == 2'd2);
   assign empty = (fill_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head = entries_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
      if (do_push) begin
         entries_ff[wptr_ff] <= push_cmd;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Push into a full queue.");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("Pop from an empty queue.");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("Queue fill level out of range.");

endmodule

// ===== sv/shdlc_rx_back.sv =====
module shdlc_rx_back #(
   parameter int FRAME_BYTES = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   input  shdlc_rx_pkg::cmd_type head,
   output logic pop,
   output shdlc_rx_pkg::release_type bank_release,
   input  logic wr_en,
   input  logic [$clog2(FRAME_BYTES):0] wr_addr,
   input  logic [7:0] wr_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_frame_byte,
   output logic [5:0] rsp_byte_index,
   output logic rsp_last
);
   import shdlc_rx_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);

   typedef enum logic [1:0] {B_IDLE, B_READ, B_LOAD} state_type;

   logic [7:0] mem [2**(AW+1)];
   logic [7:0] rd_data_ff;

   state_type state_ff, state_in;
   logic bank_ff, bank_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] final_ff, final_in;
   logic valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic last_ff, last_in;
   logic out_free;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[{bank_ff, idx_ff}];
   end

   always_comb begin
      state_in = state_ff;
      bank_in = bank_ff;
      idx_in = idx_ff;
      final_in = final_ff;
      valid_in = valid_ff && rsp_stall;
      kind_in = kind_ff;
      byte_in = byte_ff;
      index_in = index_ff;
      last_in = last_ff;
      pop = 1'b0;
      bank_release.valid = 1'b0;
      bank_release.bank = bank_ff;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               if (head.kind == KIND_BYTE) begin
                  bank_in = head.bank;
                  idx_in = '0;
                  final_in = AW'(head.emit_count - EMIT_W'(1));
                  state_in = B_READ;
               end else begin
                  valid_in = 1'b1;
                  kind_in = head.kind;
                  byte_in = 8'h00;
                  index_in = '0;
                  last_in = 1'b1;
               end
            end
         end
         B_READ: begin
            state_in = B_LOAD;
         end
         B_LOAD: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in = KIND_BYTE;
               byte_in = rd_data_ff;
               index_in = INDEX_W'(idx_ff);
               last_in = (idx_ff == final_ff);
               if (idx_ff == final_ff) begin
                  bank_release.valid = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  idx_in = idx_ff + AW'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      bank_ff <= bank_in;
      idx_ff <= idx_in;
      final_ff <= final_in;
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      index_ff <= index_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_last = last_ff;

   a_release_gives_last: assert property (@(posedge clock) disable iff (reset)
      bank_release.valid |=> valid_ff && last_ff && kind_ff == KIND_BYTE)
      else $error("Frame buffer released without its final byte.");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff != KIND_BYTE |-> last_ff && byte_ff == 8'h00
         && index_ff == '0)
      else $error("Error item carries data or is not final.");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == B_IDLE && out_free)
      else $error("Queue popped while a frame is being emitted.");

endmodule

// ===== bench/shdlc_frame_receiver_core_tb.sv =====
`timescale 1ns / 100ps

module shdlc_frame_receiver_core_tb;
   import shdlc_rx_pkg::*;

   localparam int FRAME_BYTES = 64;
   localparam int MAX_PAYLOAD = FRAME_BYTES - HEADER_BYTES - 2;
   localparam int RANDOM_ITEMS = 345;
   localparam int SEGMENT_ITEMS = 45;
   localparam int SETTLE_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic [1:0] {ST_HUNT, ST_COLLECT, ST_ESCAPED} deframe_state_type;
   typedef enum logic [1:0] {ROW_QUIET, ROW_PREDICT, ROW_ERROR} row_check_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] frame_byte;
      logic [5:0] byte_index;
      logic last;
   } deframed_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      row_check_type check;
      logic [1:0] kind;
   } rx_row_type;

   // Hunting noise, a minimal good frame with an escaped address, a bad escape,
   // a frame too short to check, and every other escape code in a short bad frame.
   rx_row_type directed_rows [24] = '{
      '{8'h00, ROW_QUIET, KIND_BYTE},
      '{BYTE_MASK, ROW_QUIET, KIND_BYTE},
      '{SYM_FLAG, ROW_QUIET, KIND_BYTE},
      '{SYM_FLAG, ROW_QUIET, KIND_BYTE},
      '{SYM_ESC, ROW_QUIET, KIND_BYTE},
      '{ESC_ESC, ROW_QUIET, KIND_BYTE},
      '{8'h00, ROW_QUIET, KIND_BYTE},
      '{8'h00, ROW_QUIET, KIND_BYTE},
      '{8'h00, ROW_QUIET, KIND_BYTE},
      '{8'h82, ROW_QUIET, KIND_BYTE},
      '{SYM_FLAG, ROW_PREDICT, KIND_BYTE},
      '{SYM_FLAG, ROW_QUIET, KIND_BYTE},
      '{SYM_ESC, ROW_QUIET, KIND_BYTE},
      '{SYM_FLAG, ROW_ERROR, KIND_BAD_ESC},
      '{SYM_FLAG, ROW_QUIET, KIND_BYTE},
      '{8'h05, ROW_QUIET, KIND_BYTE},
      '{SYM_FLAG, ROW_ERROR, KIND_BAD_FRAME},
      '{SYM_ESC, ROW_QUIET, KIND_BYTE},
      '{ESC_XON, ROW_QUIET, KIND_BYTE},
      '{SYM_ESC, ROW_QUIET, KIND_BYTE},
      '{ESC_XOFF, ROW_QUIET, KIND_BYTE},
      '{SYM_ESC, ROW_QUIET, KIND_BYTE},
      '{ESC_FLAG, ROW_QUIET, KIND_BYTE},
      '{SYM_FLAG, ROW_ERROR, KIND_BAD_FRAME}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_frame_byte;
   logic [5:0] rsp_byte_index;
   logic rsp_last;

   deframe_state_type model_state;
   int model_count;
   logic [7:0] model_store [FRAME_BYTES];
   deframed_type step_results [$];
   deframed_type pending_results [$];
   int failures = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int busy_items = 0;
   int quiet_cycles = 0;

   shdlc_frame_receiver_core #(
      .FRAME_BYTES(FRAME_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic void push_error(logic [1:0] kind);
      step_results.push_back(deframed_type'{kind, 8'h00, 6'd0, 1'b1});
   endfunction

   function automatic void abort_to_hunt(logic [1:0] kind);
      model_state = ST_HUNT;
      model_count = 0;
      push_error(kind);
   endfunction

   function automatic void store_byte(logic [7:0] d);
      if (model_count >= FRAME_BYTES) begin
         abort_to_hunt(KIND_OVERFLOW);
      end else begin
         model_store[model_count] = d;
         model_count++;
      end
   endfunction

   function automatic void deframe_step(logic [7:0] b);
      logic [7:0] sum;
      logic [7:0] d;
      logic good;
      logic escape_ok;
      step_results.delete();
      case (model_state)
         ST_COLLECT: begin
            if (b == SYM_ESC) begin
               model_state = ST_ESCAPED;
            end else if (b == SYM_FLAG && model_count == 0) begin
               model_state = ST_COLLECT;
            end else if (b == SYM_FLAG && model_count >= FRAME_BYTES) begin
               abort_to_hunt(KIND_OVERFLOW);
            end else if (b == SYM_FLAG) begin
               sum = 8'h00;
               for (int i = 0; i < model_count - 1; i++) begin
                  sum += model_store[i];
               end
               good = model_count >= HEADER_BYTES + 1
                  && model_count == model_store[LEN_OFFSET] + HEADER_BYTES + 1
                  && model_store[model_count - 1] == ~sum;
               if (!good) begin
                  model_count = 0;
                  model_state = ST_COLLECT;
                  push_error(KIND_BAD_FRAME);
               end else begin
                  for (int i = 0; i < model_count - 1; i++) begin
                     step_results.push_back(deframed_type'{KIND_BYTE, model_store[i], 6'(i),
                                                           i == model_count - 2});
                  end
                  model_count = 0;
                  model_state = ST_HUNT;
               end
            end else begin
               store_byte(b);
            end
         end
         ST_ESCAPED: begin
            escape_ok = 1'b1;
            d = 8'h00;
            case (b)
               ESC_FLAG: d = SYM_FLAG;
               ESC_ESC: d = SYM_ESC;
               ESC_XON: d = CHR_XON;
               ESC_XOFF: d = CHR_XOFF;
               default: escape_ok = 1'b0;
            endcase
            if (escape_ok) begin
               model_state = ST_COLLECT;
               store_byte(d);
            end else begin
               abort_to_hunt(KIND_BAD_ESC);
            end
         end
         default: begin
            if (b == SYM_FLAG) begin
               model_count = 0;
               model_state = ST_COLLECT;
            end
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      logic [7:0] specials [6] = '{SYM_FLAG, SYM_ESC, CHR_XON, CHR_XOFF, 8'h00, BYTE_MASK};
      if ($urandom_range(3) == 0) begin
         return specials[$urandom_range(5)];
      end
      return 8'($urandom_range(255));
   endfunction

   task automatic send_rx_byte(input logic [7:0] b, input row_check_type check,
                               input logic [1:0] kind);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      if (model_state != ST_HUNT || b == SYM_FLAG) begin
         busy_items++;
      end
      deframe_step(b);
      case (check)
         ROW_PREDICT: begin
            foreach (step_results[i]) begin
               pending_results.push_back(step_results[i]);
            end
         end
         ROW_ERROR: pending_results.push_back(deframed_type'{kind, 8'h00, 6'd0, 1'b1});
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   always @(posedge clock) begin
      deframed_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected item: kind %0d, byte %02h, index %0d, last %0b",
                   rsp_result_kind, rsp_frame_byte, rsp_byte_index, rsp_last);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_result_kind !== want.kind) begin
               $error("rsp_result_kind: expected %0d, actual %0d", want.kind, rsp_result_kind);
               failures++;
            end
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("rsp_frame_byte: expected %02h, actual %02h",
                      want.frame_byte, rsp_frame_byte);
               failures++;
            end
            if (rsp_byte_index !== want.byte_index) begin
               $error("rsp_byte_index: expected %0d, actual %0d",
                      want.byte_index, rsp_byte_index);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0b, actual %0b", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [7:0] raw [$];
      logic [7:0] line_bytes [$];
      logic [7:0] csum;
      logic [7:0] code;
      int flavour;
      int r;
      int payload_len;
      int bad_pos;
      int segment;
      int last_segment;

      for (int i = 0; i < FRAME_BYTES; i++) begin
         model_store[i] = 8'h00;
      end
      model_state = ST_HUNT;
      model_count = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_rx_byte(directed_rows[i].rx_byte, directed_rows[i].check, directed_rows[i].kind);
      end

      busy_items = 0;
      last_segment = -1;
      while (busy_items < RANDOM_ITEMS) begin
         segment = busy_items / SEGMENT_ITEMS;
         if (segment != last_segment) begin
            last_segment = segment;
            wait_for_results();
            case (segment % 4)
               0: begin
                  send_idle_pct = 0;
                  stall_pct = 0;
               end
               1: begin
                  send_idle_pct = 72;
                  stall_pct = 0;
               end
               2: begin
                  send_idle_pct = 0;
                  stall_pct = 72;
               end
               default: begin
                  send_idle_pct = 33;
                  stall_pct = 33;
               end
            endcase
         end

         raw.delete();
         line_bytes.delete();
         bad_pos = -1;
         flavour = $urandom_range(99);
         if (flavour < 86) begin
            r = $urandom_range(99);
            payload_len = (r < 6) ? MAX_PAYLOAD
                        : (r < 16) ? $urandom_range(MAX_PAYLOAD) : $urandom_range(8);
            for (int i = 0; i < LEN_OFFSET; i++) begin
               raw.push_back(pick_byte());
            end
            raw.push_back(8'(payload_len));
            for (int i = 0; i < payload_len; i++) begin
               raw.push_back(pick_byte());
            end
            // A wrong length byte with a checksum that still covers it.
            if (flavour >= 72 && flavour < 79) begin
               raw[LEN_OFFSET] += 8'($urandom_range(1, 255));
            end
            csum = 8'h00;
            foreach (raw[i]) begin
               csum += raw[i];
            end
            csum = ~csum;
            if (flavour >= 65 && flavour < 72) begin
               csum ^= 8'($urandom_range(1, 255));
            end
            raw.push_back(csum);
            if (flavour >= 79) begin
               bad_pos = $urandom_range(raw.size() - 1);
            end
         end else if (flavour < 92) begin
            repeat (FRAME_BYTES + $urandom_range(2)) raw.push_back(pick_byte());
         end else if (flavour < 96) begin
            repeat ($urandom_range(HEADER_BYTES)) raw.push_back(pick_byte());
         end

         if (flavour < 96) begin
            repeat (($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0) begin
               line_bytes.push_back(pick_byte());
            end
            line_bytes.push_back(SYM_FLAG);
            if ($urandom_range(5) == 0) begin
               line_bytes.push_back(SYM_FLAG);
            end
            foreach (raw[i]) begin
               if (i == bad_pos) begin
                  if ($urandom_range(3) == 0) begin
                     code = SYM_FLAG;
                  end else begin
                     do code = 8'($urandom_range(255));
                     while (code inside {ESC_FLAG, ESC_ESC, ESC_XON, ESC_XOFF});
                  end
                  line_bytes.push_back(SYM_ESC);
                  line_bytes.push_back(code);
               end
               case (raw[i])
                  SYM_FLAG: begin
                     line_bytes.push_back(SYM_ESC);
                     line_bytes.push_back(ESC_FLAG);
                  end
                  SYM_ESC: begin
                     line_bytes.push_back(SYM_ESC);
                     line_bytes.push_back(ESC_ESC);
                  end
                  CHR_XON: begin
                     line_bytes.push_back(SYM_ESC);
                     line_bytes.push_back(ESC_XON);
                  end
                  CHR_XOFF: begin
                     line_bytes.push_back(SYM_ESC);
                     line_bytes.push_back(ESC_XOFF);
                  end
                  default: line_bytes.push_back(raw[i]);
               endcase
            end
            line_bytes.push_back(SYM_FLAG);
         end else begin
            repeat ($urandom_range(2, 10)) line_bytes.push_back(pick_byte());
         end

         foreach (line_bytes[i]) begin
            send_rx_byte(line_bytes[i], ROW_PREDICT, KIND_BYTE);
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
